@@ rtl/sca_pkg.sv @@
package sca_pkg;

  localparam int OPCODE_W   = 2;
  localparam int BYTES_W    = 24;
  localparam int ADDR_W     = 26;
  localparam int CLASS_W    = 7;
  localparam int STATUS_W   = 2;
  localparam int CHUNK_W    = 21;
  localparam int PAGES_W    = 13;
  localparam int BASE_W     = 20;
  localparam int FACTOR_W   = 11;
  localparam int SIZE_W     = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_INIT  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_ALLOC = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_FREE  = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_NOP   = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOFIT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OOM   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FACTOR    = 2'd2;

  localparam logic [FACTOR_W-1:0] FACTOR_ONE       = 11'd256;
  localparam logic [FACTOR_W-1:0] FACTOR_TWO       = 11'd512;
  localparam logic [BASE_W-1:0]   DOUBLING_MIN     = 20'd128;
  localparam logic [BASE_W-1:0]   BASE_RESET       = 20'd48;
  localparam logic [FACTOR_W-1:0] FACTOR_RESET     = 11'd320;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [BYTES_W-1:0]  request_bytes;
    logic [ADDR_W-1:0]   free_address;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   address;
    logic [CLASS_W-1:0]  class_id;
    logic [CLASS_W-1:0]  class_count;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_INIT_CHK,
    S_INIT_DIV,
    S_FIND_RD,
    S_FIND_CMP,
    S_CLS_RD,
    S_CLS_EVAL,
    S_PAGE_MUL,
    S_PAGE_GO,
    S_POP_RD,
    S_POP_OUT,
    S_RESP
  } state_t;

endpackage

@@ rtl/sca_div.sv @@
module sca_div #(
  parameter int W = 21
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);

  localparam int CNT_W = $clog2(W + 1);

  logic             run;
  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     rem;
  logic [W-1:0]     quo;
  logic [W-1:0]     dvs;
  logic [W:0]       trial;
  logic [W:0]       diff;

  // one quotient bit per cycle, restoring
  assign trial    = {rem, quo[W-1]};
  assign diff     = trial - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (run) begin
      if (!diff[W]) begin
        rem <= diff[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= trial[W-1:0];
        quo <= {quo[W-2:0], 1'b0};
      end
    end
  end

endmodule

@@ rtl/slab_class_allocator_unit.sv @@
// Channel    Handshake                 Payload
// command    start / busy              cmd      (opcode, request_bytes, free_address)
// result     done, one-cycle strobe    result   (status, address, class_id, class_count)
// config     cfg_valid / cfg_ready     cfg_index, cfg_data
//
// Steps: init runs decode, then builds each class in turn, paced by the shared restoring
// divider that forms chunks-per-page one bit a cycle, then writes the closing class and the result.
// Allocate and free run decode, a read and compare per class walked in the size search,
// class state read, update and result, plus pop read and output for a pop or page multiply and go for a new page.
// busy falls as the result strobe rises; rst (synchronous) clears control state, per-class
// valid bits and configuration, not the free stack. The receiver cannot stall.
// ALIGN_BYTES is taken to be a power of two.
module slab_class_allocator_unit #(
  parameter int MAX_CLASSES = 64,
  parameter int PAGE_BYTES  = 1048576,
  parameter int ALIGN_BYTES = 8,
  parameter int FREE_DEPTH  = 256,
  parameter int MAX_PAGES   = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  sca_pkg::cmd_t                   cmd,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sca_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sca_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                            done,
  output sca_pkg::result_t                result
);

  import sca_pkg::*;

  localparam int NCLS   = MAX_CLASSES + 1;
  localparam int CW     = $clog2(NCLS);
  localparam int RW     = $clog2(NCLS + 1);
  localparam int TW     = $clog2(FREE_DEPTH + 1);
  localparam int SIW    = $clog2(FREE_DEPTH);
  localparam int SAW    = CW + SIW;
  localparam int SDEPTH = NCLS * (1 << SIW);

  localparam logic [SIZE_W-1:0]  HALF_PAGE  = SIZE_W'(PAGE_BYTES / 2);
  localparam logic [SIZE_W-1:0]  ALIGN_LOW  = SIZE_W'(ALIGN_BYTES - 1);
  localparam logic [CHUNK_W-1:0] PAGE_CHUNK = CHUNK_W'(PAGE_BYTES);

  // per-class allocation state, held in one memory word
  typedef struct packed {
    logic [TW-1:0]      top;
    logic [ADDR_W-1:0]  bump;
    logic [CHUNK_W-1:0] rem;
    logic [CLASS_W-1:0] pages;
  } cls_state_t;

  state_t state, state_next;

  // configuration
  logic [PAGES_W-1:0]  page_cap;
  logic [BASE_W-1:0]   base;
  logic [FACTOR_W-1:0] factor;

  // command and working registers
  logic [OPCODE_W-1:0] op;
  logic [BYTES_W-1:0]  bytes;
  logic [ADDR_W-1:0]   faddr;
  logic [SIZE_W-1:0]   size;
  logic [FACTOR_W-1:0] fac;
  logic [CW-1:0]       idx;
  logic [RW-1:0]       rptr;
  logic [CW-1:0]       cls;
  logic [CHUNK_W-1:0]  csize;
  logic [CW-1:0]       largest;
  logic [PAGES_W-1:0]  pages_used;
  logic [ADDR_W-1:0]   page_base;
  logic [NCLS-1:0]     cls_valid;
  logic [SAW-1:0]      stack_raddr;
  result_t             res;

  // memories
  logic [CHUNK_W-1:0] size_mem  [NCLS];
  logic [CHUNK_W-1:0] cpp_mem   [NCLS];
  cls_state_t         cls_mem   [NCLS];
  logic [ADDR_W-1:0]  stack_mem [SDEPTH];
  logic [CHUNK_W-1:0] size_rd;
  logic [CHUNK_W-1:0] cpp_rd;
  cls_state_t         cls_rd;
  logic [ADDR_W-1:0]  stack_rd;

  // control
  logic               tab_we;
  logic [CHUNK_W-1:0] tab_size;
  logic [CHUNK_W-1:0] tab_cpp;
  logic               cls_we;
  cls_state_t         cls_wdata;
  logic               stack_we;
  logic               div_start;
  logic               div_done;
  logic [CHUNK_W-1:0] div_q;

  // datapath helpers
  cls_state_t          cst;
  logic [SIZE_W-1:0]   aligned;
  logic                init_go;
  logic                is_mem_op;
  logic                top_nz;
  logic                rem_nz;
  logic                stack_full;
  logic                page_fail;
  logic                matched;
  logic                past_end;
  logic [ADDR_W-1:0]   src_addr;
  logic [CHUNK_W-1:0]  src_rem;
  logic [CHUNK_W-1:0]  step_rem;
  logic [ADDR_W-1:0]   step_bump;
  logic [BASE_W-1:0]   base_eff;
  logic [FACTOR_W+CHUNK_W-1:0] grow_prod;
  logic [PAGES_W+CHUNK_W-1:0]  page_prod;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign result    = res;

  // ---------------------------------------------------------------------------
  // Shared divider: chunks per page = PAGE_BYTES / chunk size
  // ---------------------------------------------------------------------------
  sca_div #(
    .W(CHUNK_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (PAGE_CHUNK),
    .divisor  (aligned[CHUNK_W-1:0]),
    .done     (div_done),
    .quotient (div_q)
  );

  // ---------------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------------
  // an invalid class entry reads as all zero (cleared by reset and by init)
  assign cst        = cls_valid[cls] ? cls_rd : '0;
  assign aligned    = (size + ALIGN_LOW) & ~ALIGN_LOW;
  assign init_go    = (idx < CW'(MAX_CLASSES)) && (size <= HALF_PAGE);
  assign is_mem_op  = (op == OP_ALLOC) || (op == OP_FREE);
  assign top_nz     = (cst.top != '0);
  assign rem_nz     = (cst.rem != '0);
  assign stack_full = (cst.top >= TW'(FREE_DEPTH));
  assign page_fail  = ((page_cap != '0) &&
                       ({1'b0, pages_used} + 1'b1 > {1'b0, page_cap}) &&
                       (cst.pages != '0)) ||
                      (pages_used >= PAGES_W'(MAX_PAGES));
  assign matched    = ({{(CHUNK_W){1'b0}}, bytes} <= {{(BYTES_W){1'b0}}, size_rd});
  assign past_end   = (rptr > RW'(largest));
  assign base_eff   = (base == '0) ? BASE_W'(1) : base;
  assign grow_prod  = size[CHUNK_W-1:0] * fac;
  assign page_prod  = pages_used * PAGE_CHUNK;

  // bump step: take the chunk at src_addr, advance within the page
  assign src_addr  = (state == S_PAGE_GO) ? page_base : cst.bump;
  assign src_rem   = (state == S_PAGE_GO) ? cpp_rd : cst.rem;
  assign step_rem  = src_rem - 1'b1;
  assign step_bump = (step_rem != '0) ? (src_addr + ADDR_W'(csize)) : '0;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      page_cap <= '0;
      base     <= BASE_RESET;
      factor   <= FACTOR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MEM_LIMIT: page_cap <= cfg_data[PAGES_W-1:0];
        CFG_BASE:      base     <= cfg_data[BASE_W-1:0];
        CFG_FACTOR:    factor   <= cfg_data[FACTOR_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (start) state_next = S_DECODE;
      S_DECODE: begin
        if (op == OP_INIT) begin
          state_next = S_INIT_CHK;
        end else if (is_mem_op && (bytes != '0)) begin
          state_next = S_FIND_RD;
        end else begin
          state_next = S_RESP;
        end
      end
      S_INIT_CHK: state_next = init_go ? S_INIT_DIV : S_RESP;
      S_INIT_DIV: if (div_done) state_next = S_INIT_CHK;
      S_FIND_RD:  state_next = past_end ? S_RESP : S_FIND_CMP;
      S_FIND_CMP: state_next = matched ? S_CLS_RD : S_FIND_RD;
      S_CLS_RD:   state_next = S_CLS_EVAL;
      S_CLS_EVAL: begin
        if (op == OP_ALLOC) begin
          if (top_nz) begin
            state_next = S_POP_RD;
          end else if (rem_nz || page_fail) begin
            state_next = S_RESP;
          end else begin
            state_next = S_PAGE_MUL;
          end
        end else begin
          state_next = S_RESP;
        end
      end
      S_PAGE_MUL: state_next = S_PAGE_GO;
      S_PAGE_GO:  state_next = S_RESP;
      S_POP_RD:   state_next = S_POP_OUT;
      S_POP_OUT:  state_next = S_RESP;
      S_RESP:     state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: memory write strobes and write data
  // ---------------------------------------------------------------------------
  always_comb begin
    tab_we    = 1'b0;
    tab_size  = size[CHUNK_W-1:0];
    tab_cpp   = div_q;
    cls_we    = 1'b0;
    cls_wdata = cst;
    stack_we  = 1'b0;
    div_start = 1'b0;
    unique case (state)
      S_INIT_CHK: begin
        if (init_go) begin
          div_start = 1'b1;
        end else begin
          // closing class holds one whole page
          tab_we   = 1'b1;
          tab_size = PAGE_CHUNK;
          tab_cpp  = CHUNK_W'(1);
        end
      end
      S_INIT_DIV: tab_we = div_done;
      S_CLS_EVAL: begin
        if (op == OP_ALLOC) begin
          if (top_nz) begin
            cls_we        = 1'b1;
            cls_wdata.top = cst.top - 1'b1;
          end else if (rem_nz) begin
            cls_we         = 1'b1;
            cls_wdata.bump = step_bump;
            cls_wdata.rem  = step_rem;
          end
        end else if (!stack_full) begin
          cls_we        = 1'b1;
          stack_we      = 1'b1;
          cls_wdata.top = cst.top + 1'b1;
        end
      end
      S_PAGE_GO: begin
        cls_we         = 1'b1;
        cls_wdata.bump = step_bump;
        cls_wdata.rem  = step_rem;
        if (cst.pages != {CLASS_W{1'b1}}) begin
          cls_wdata.pages = cst.pages + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Memories: registered reads, one write port each
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    size_rd <= size_mem[rptr[CW-1:0]];
    if (tab_we) begin
      size_mem[idx] <= tab_size;
    end
  end

  always_ff @(posedge clk) begin
    cpp_rd <= cpp_mem[cls];
    if (tab_we) begin
      cpp_mem[idx] <= tab_cpp;
    end
  end

  always_ff @(posedge clk) begin
    cls_rd <= cls_mem[cls];
    if (cls_we) begin
      cls_mem[cls] <= cls_wdata;
    end
  end

  always_ff @(posedge clk) begin
    stack_rd <= stack_mem[stack_raddr];
    if (stack_we) begin
      stack_mem[{cls, cst.top[SIW-1:0]}] <= faddr;
    end
  end

  // ---------------------------------------------------------------------------
  // Control state with reset
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      done       <= 1'b0;
      largest    <= '0;
      pages_used <= '0;
      cls_valid  <= '0;
    end else begin
      done <= (state == S_RESP);
      if (state == S_DECODE && op == OP_INIT) begin
        // drop all per-class state; pages handed out stay consumed
        cls_valid <= '0;
        largest   <= '0;
      end
      if (state == S_INIT_CHK && !init_go) begin
        largest <= idx;
      end
      if (cls_we) begin
        cls_valid[cls] <= 1'b1;
      end
      if (state == S_PAGE_GO) begin
        pages_used <= pages_used + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Working registers and result
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          op    <= cmd.opcode;
          bytes <= cmd.request_bytes;
          faddr <= cmd.free_address;
          res   <= '0;
        end
      end
      S_DECODE: begin
        fac  <= (factor < FACTOR_ONE) ? FACTOR_ONE : factor;
        size <= ((factor == FACTOR_TWO) && (base_eff < DOUBLING_MIN)) ?
                SIZE_W'(DOUBLING_MIN) : SIZE_W'(base_eff);
        idx  <= CW'(1);
        rptr <= RW'(1);
        if (is_mem_op && (bytes == '0)) begin
          res.status <= ST_NOFIT;
        end
      end
      S_INIT_CHK: begin
        if (init_go) begin
          size <= aligned;
        end
      end
      S_INIT_DIV: begin
        if (div_done) begin
          size <= SIZE_W'(grow_prod >> 8);
          idx  <= idx + 1'b1;
        end
      end
      S_FIND_RD: begin
        if (past_end) begin
          res.status <= ST_NOFIT;
        end
      end
      S_FIND_CMP: begin
        if (matched) begin
          cls          <= rptr[CW-1:0];
          csize        <= size_rd;
          res.class_id <= CLASS_W'(rptr);
        end else begin
          rptr <= rptr + 1'b1;
        end
      end
      S_CLS_EVAL: begin
        if (op == OP_ALLOC) begin
          if (top_nz) begin
            stack_raddr <= {cls, SIW'(cst.top - 1'b1)};
          end else if (rem_nz) begin
            res.address <= cst.bump;
          end else if (page_fail) begin
            res.status <= ST_OOM;
          end
        end else if (stack_full) begin
          res.status <= ST_FULL;
        end
      end
      S_PAGE_MUL: page_base   <= page_prod[ADDR_W-1:0];
      S_PAGE_GO:  res.address <= page_base;
      S_POP_OUT:  res.address <= stack_rd;
      S_RESP:     res.class_count <= CLASS_W'(largest);
      default: ;
    endcase
  end

endmodule

@@ rtl/sca_chk.sv @@
module sca_chk (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input sca_pkg::result_t result
);

  import sca_pkg::*;

  // a result only ends a command that was in progress
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a command in progress");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("command transfer did not raise busy");

  // one result per command, never two in a row
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe repeated");

  a_addr_on_error: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status != ST_OK)) |-> (result.address == '0))
    else $error("address driven on a failed command");

  a_nofit_class: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == ST_NOFIT)) |-> (result.class_id == '0))
    else $error("class reported on a no-fit result");

endmodule

bind slab_class_allocator_unit sca_chk u_sca_chk (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
